// File: rtl/fhn_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhn_pkg
// Shared types, constants and saturation helpers for the FitzHugh-Nagumo
// reaction solver.
// ---------------------------------------------------------------------------
package fhn_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int MAX_STEPS_DEF  = 100;
    localparam int BETA_Q_DEF     = 65536;
    localparam int DELTA_Q_DEF    = 6554;
    localparam int GAMMA_Q_DEF    = 6554;

    localparam int NODE_W   = 12;
    localparam int CFG_IDX_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPLICIT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REST      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOLAR   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 4'd7;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_CLEAR, ST_MOD, ST_RD,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
        ST_P10, ST_P11, ST_P12, ST_P13, ST_P14, ST_P15, ST_P16, ST_P17, ST_P18,
        ST_P19, ST_P20,
        ST_IT0, ST_IT1, ST_IT2, ST_IT3, ST_IT4, ST_IT5, ST_IT6, ST_IT7, ST_IT8,
        ST_IT9, ST_H1, ST_H2, ST_H3, ST_H4, ST_ITD, ST_FIN
    } state_t;

    function automatic logic signed [63:0] sx64(input logic signed [31:0] x);
        sx64 = {{32{x[31]}}, x};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF)
            sat32 = 32'sh7FFF_FFFF;
        else if (x < -64'sh0000_0000_8000_0000)
            sat32 = 32'sh8000_0000;
        else
            sat32 = x[31:0];
    endfunction

endpackage

// File: rtl/fhn_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhn_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module fhn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/fhn_qmul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhn_qmul
// Shared Q16.16 multiplier: registered full product, floor shift and
// saturation on the way out.
// ---------------------------------------------------------------------------
module fhn_qmul
    import fhn_pkg::*;
(
    input  logic               clk,
    input  logic               go,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] res
);

    logic signed [63:0] prod_reg;

    // hold the product until the next issue
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            prod_reg <= sx64(a) * sx64(b);
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign res = sat32(prod_reg >>> 16);

endmodule

// File: rtl/fhn_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhn_div
// Bit-serial Q16.16 divider: (num * 65536) / den, truncated toward zero and
// saturated, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fhn_div
    import fhn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic signed [31:0] quo,
    output div_stat_t          stat
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg;
    logic [32:0] rem_reg, rem_next;
    logic [47:0] dq_reg, dq_next;
    logic [31:0] b_reg;
    logic signed [31:0] quo_reg;

    logic [32:0] na_abs, db_abs, rem_sh;
    logic        ge;

    assign na_abs = num[31] ? (33'd0 - {1'b1, num}) : {1'b0, num};
    assign db_abs = den[31] ? (33'd0 - {1'b1, den}) : {1'b0, den};

    // one restoring step
    always_comb
    begin
        rem_sh  = {rem_reg[31:0], dq_reg[47]};
        ge      = (rem_sh >= {1'b0, b_reg});
        rem_next = ge ? (rem_sh - {1'b0, b_reg}) : rem_sh;
        dq_next  = {dq_reg[46:0], ge};
    end

    // control: done holds until the next start
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = (den != 32'sd0);
            done_next = (den == 32'sd0);
            cnt_next  = 6'd0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[31] ^ den[31];
            rem_reg <= 33'd0;
            dq_reg  <= {na_abs[31:0], 16'd0};
            b_reg   <= db_abs[31:0];
            if (den == 32'sd0)
            begin
                if (num == 32'sd0)
                    quo_reg <= 32'sd0;
                else if (num[31])
                    quo_reg <= 32'sh8000_0000;
                else
                    quo_reg <= 32'sh7FFF_FFFF;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            if (cnt_reg == 6'd47)
            begin
                if (neg_reg)
                    quo_reg <= (dq_next > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                              : (32'sd0 - dq_next[31:0]);
                else
                    quo_reg <= (dq_next > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                              : dq_next[31:0];
            end
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/fhn_reaction_newton_step_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhn_reaction_newton_step_unit
// Implicit FitzHugh-Nagumo reaction update per mesh node with stored
// recovery variable and Newton or Halley iteration.
// ---------------------------------------------------------------------------
// One node is processed at a time. After reset the recovery store is cleared
// before the first item is taken. An item then passes through reduction of
// the node index, the recovery update (which waits on the divider), and one
// pass of the solver per iteration, a Newton pass or a Halley pass, up to
// MAX_STEPS + 1 passes, plus a write-back. The schedule is set by the shared
// bit-serial divider and the single shared multiplier. A result may wait in
// the output register while the next item is already computed.
// ---------------------------------------------------------------------------
module fhn_reaction_newton_step_unit
    import fhn_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF,
    parameter int BETA_Q     = BETA_Q_DEF,
    parameter int DELTA_Q    = DELTA_Q_DEF,
    parameter int GAMMA_Q    = GAMMA_Q_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // node_index[11:0], potential[43:12]
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [87:0]          m_tdata,   // node_out[11:0], new_potential[43:12],
                                            // new_recovery[75:44], steps_taken[82:76]
    output logic                 m_tuser,   // flat_stop[0]
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int STEP_W = $clog2(MAX_STEPS + 2);

    // configuration registers
    logic [30:0]        inv_step_reg;
    logic [16:0]        split_reg, implicit_reg;
    logic signed [31:0] gain_reg, rest_reg, thr_reg, dep_reg;
    logic               mode_reg;

    state_t state_reg, state_next;

    logic [ADDR_W:0]    clr_reg;
    logic [3:0]         k_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic               out_valid_reg;

    // payload
    logic [NODE_W-1:0]  node_reg, r_reg;
    logic signed [31:0] v_reg, v0_reg, w_reg;
    logic signed [31:0] ag_reg, ald_reg, den_reg, t1_reg, x4_reg, num_reg;
    logic signed [31:0] alth_reg, alom_reg, atc_reg, btc_reg, p_reg, cu_reg;
    logic signed [31:0] z1_reg, z2_reg, y1_reg, y2_reg, pairs_reg, alb_reg;
    logic signed [31:0] wnew_reg, k0_reg, s_reg;
    logic signed [31:0] dv_reg, vv_reg, sv_reg, f_reg, q_reg, ddf_reg, df_reg;
    logic signed [31:0] hn_reg, dd_reg, hd_reg;
    logic               flat_reg;
    logic [NODE_W-1:0]  o_node_reg;
    logic signed [31:0] o_v_reg, o_w_reg;
    logic [6:0]         o_steps_reg;
    logic               o_flat_reg;

    // shared units
    logic               mul_go;
    logic signed [31:0] mul_a, mul_b, m;
    logic               div_start;
    logic signed [31:0] div_n, div_d, quo;
    div_stat_t          div_stat;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  slot, ram_waddr;
    logic [31:0]        ram_wdata, ram_rdata;

    logic signed [31:0] d32, al32, th32, omt32, ca, cb, cc, e6, vn;
    logic [32:0]        mod_cmp;
    logic [8:0]         steps9, steps_inc9;
    logic               accept, out_free, cont;

    assign d32   = {1'b0, inv_step_reg};
    assign al32  = {15'd0, split_reg};
    assign th32  = {15'd0, implicit_reg};
    assign omt32 = 32'sd65536 - th32;
    assign ca    = sat32(sx64(v_reg) - sx64(rest_reg));
    assign cb    = sat32(sx64(v_reg) - sx64(dep_reg));
    assign cc    = sat32(sx64(v_reg) - sx64(thr_reg));
    assign e6    = sat32(sx64(v_reg) * 64'sd6 - (sx64(s_reg) <<< 1));
    assign vn    = sat32(sx64(v_reg) - sx64(quo));
    assign mod_cmp    = 33'(NODE_COUNT) << k_reg;
    assign slot       = ADDR_W'(r_reg);
    assign steps9     = 9'(steps_reg);
    assign steps_inc9 = steps9 + 9'd1;
    assign cont       = (steps_inc9 <= 9'(MAX_STEPS)) && (vn != v_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    fhn_qmul u_mul (
        .clk (clk),
        .go  (mul_go),
        .a   (mul_a),
        .b   (mul_b),
        .res (m)
    );

    fhn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (div_d),
        .quo   (quo),
        .stat  (div_stat)
    );

    fhn_ram #(
        .WIDTH (32),
        .DEPTH (NODE_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_step_reg <= 31'd65536;
            split_reg    <= 17'd32768;
            implicit_reg <= 17'd32768;
            gain_reg     <= 32'sd65536;
            rest_reg     <= 32'sd0;
            thr_reg      <= 32'sd6554;
            dep_reg      <= 32'sd65536;
            mode_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INV_STEP:  inv_step_reg <= cfg_data[30:0];
                CFG_SPLIT:     split_reg    <= cfg_data[16:0];
                CFG_IMPLICIT:  implicit_reg <= cfg_data[16:0];
                CFG_GAIN:      gain_reg     <= cfg_data;
                CFG_REST:      rest_reg     <= cfg_data;
                CFG_THRESHOLD: thr_reg      <= cfg_data;
                CFG_DEPOLAR:   dep_reg      <= cfg_data;
                CFG_MODE:      mode_reg     <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state, unit operands and memory control
    always_comb
    begin
        state_next = state_reg;
        mul_go     = 1'b1;
        mul_a      = 32'sd0;
        mul_b      = 32'sd0;
        div_start  = 1'b0;
        div_n      = f_reg;
        div_d      = df_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = slot;
        ram_wdata  = wnew_reg;
        case (state_reg)
            ST_IDLE:
            begin
                mul_go = 1'b0;
                if (accept)
                    state_next = ST_MOD;
            end
            ST_CLEAR:
            begin
                mul_go    = 1'b0;
                ram_we    = 1'b1;
                ram_waddr = clr_reg[ADDR_W-1:0];
                ram_wdata = 32'd0;
                if (clr_reg == (ADDR_W+1)'(NODE_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_MOD:
            begin
                mul_go = 1'b0;
                if (k_reg == 4'd0)
                    state_next = ST_RD;
            end
            ST_RD:
            begin
                mul_go     = 1'b0;
                ram_re     = 1'b1;
                state_next = ST_P0;
            end
            ST_P0:  begin mul_a = al32;     mul_b = 32'(GAMMA_Q); state_next = ST_P1;  end
            ST_P1:  begin mul_a = al32;     mul_b = 32'(DELTA_Q); state_next = ST_P2;  end
            ST_P2:  begin mul_a = ag_reg;   mul_b = th32;         state_next = ST_P3;  end
            ST_P3:  begin mul_a = ag_reg;   mul_b = omt32;        state_next = ST_P4;  end
            ST_P4:  begin mul_a = ald_reg;  mul_b = v0_reg;       state_next = ST_P5;  end
            ST_P5:  begin mul_a = t1_reg;   mul_b = w_reg;        state_next = ST_P6;  end
            ST_P6:  begin mul_a = al32;     mul_b = th32;         state_next = ST_P7;  end
            ST_P7:  begin mul_a = al32;     mul_b = omt32;        state_next = ST_P8;  end
            ST_P8:
            begin
                mul_a      = alth_reg;
                mul_b      = gain_reg;
                div_start  = 1'b1;
                div_n      = num_reg;
                div_d      = den_reg;
                state_next = ST_P9;
            end
            ST_P9:  begin mul_a = alom_reg; mul_b = gain_reg;     state_next = ST_P10; end
            ST_P10: begin mul_a = ca;       mul_b = cb;           state_next = ST_P11; end
            ST_P11: begin mul_a = thr_reg;  mul_b = dep_reg;      state_next = ST_P12; end
            ST_P12: begin mul_a = p_reg;    mul_b = cc;           state_next = ST_P13; end
            ST_P13: begin mul_a = thr_reg;  mul_b = rest_reg;     state_next = ST_P14; end
            ST_P14: begin mul_a = btc_reg;  mul_b = cu_reg;       state_next = ST_P15; end
            ST_P15: begin mul_a = rest_reg; mul_b = dep_reg;      state_next = ST_P16; end
            ST_P16: begin mul_a = d32;      mul_b = v0_reg;       state_next = ST_P17; end
            ST_P17: begin mul_a = al32;     mul_b = 32'(BETA_Q);  state_next = ST_P18; end
            ST_P18:
            begin
                mul_go = 1'b0;
                if (div_stat.done)
                    state_next = ST_P19;
            end
            ST_P19: begin mul_a = alb_reg;  mul_b = wnew_reg;     state_next = ST_P20; end
            ST_P20: begin mul_go = 1'b0;                          state_next = ST_IT0; end
            ST_IT0: begin mul_a = d32;      mul_b = v_reg;        state_next = ST_IT1; end
            ST_IT1: begin mul_a = ca;       mul_b = cb;           state_next = ST_IT2; end
            ST_IT2: begin mul_a = v_reg;    mul_b = v_reg;        state_next = ST_IT3; end
            ST_IT3: begin mul_a = p_reg;    mul_b = cc;           state_next = ST_IT4; end
            ST_IT4: begin mul_a = s_reg;    mul_b = v_reg;        state_next = ST_IT5; end
            ST_IT5: begin mul_a = atc_reg;  mul_b = cu_reg;       state_next = ST_IT6; end
            ST_IT6: begin mul_a = atc_reg;  mul_b = e6;           state_next = ST_IT7; end
            ST_IT7: begin mul_a = atc_reg;  mul_b = q_reg;        state_next = ST_IT8; end
            ST_IT8: begin mul_go = 1'b0;                          state_next = ST_IT9; end
            ST_IT9:
            begin
                mul_a = f_reg;
                mul_b = df_reg;
                if (df_reg == 32'sd0)
                begin
                    mul_go     = 1'b0;
                    state_next = ST_FIN;
                end
                else if (mode_reg)
                begin
                    mul_go     = 1'b0;
                    div_start  = 1'b1;
                    state_next = ST_ITD;
                end
                else
                begin
                    state_next = ST_H1;
                end
            end
            ST_H1:  begin mul_a = df_reg;   mul_b = df_reg;       state_next = ST_H2;  end
            ST_H2:  begin mul_a = f_reg;    mul_b = ddf_reg;      state_next = ST_H3;  end
            ST_H3:  begin mul_go = 1'b0;                          state_next = ST_H4;  end
            ST_H4:
            begin
                mul_go     = 1'b0;
                div_start  = 1'b1;
                div_n      = hn_reg;
                div_d      = hd_reg;
                state_next = ST_ITD;
            end
            ST_ITD:
            begin
                mul_go = 1'b0;
                if (div_stat.done)
                    state_next = cont ? ST_IT0 : ST_FIN;
            end
            ST_FIN:
            begin
                mul_go = 1'b0;
                ram_we = 1'b1;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                mul_go     = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
    end

    // control counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            k_reg         <= 4'd0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + (ADDR_W+1)'(1);
            if (accept)
                k_reg <= 4'd11;
            else if (state_reg == ST_MOD && k_reg != 4'd0)
                k_reg <= k_reg - 4'd1;
            if (accept)
                steps_reg <= '0;
            else if (state_reg == ST_ITD && div_stat.done)
                steps_reg <= steps_reg + STEP_W'(1);
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath: capture the previous product and advance the solver
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    node_reg <= s_tdata[11:0];
                    r_reg    <= s_tdata[11:0];
                    v0_reg   <= s_tdata[43:12];
                    v_reg    <= s_tdata[43:12];
                    flat_reg <= 1'b0;
                end
            end
            ST_MOD:
            begin
                if ({21'd0, r_reg} >= mod_cmp)
                    r_reg <= NODE_W'({21'd0, r_reg} - mod_cmp);
            end
            ST_P0:
            begin
                w_reg <= ram_rdata;
                s_reg <= sat32(sx64(rest_reg) + sx64(dep_reg) + sx64(thr_reg));
            end
            ST_P1:  ag_reg    <= m;
            ST_P2:  ald_reg   <= m;
            ST_P3:  den_reg   <= sat32(sx64(d32) + sx64(m));
            ST_P4:  t1_reg    <= sat32(sx64(d32) - sx64(m));
            ST_P5:  x4_reg    <= m;
            ST_P6:  num_reg   <= sat32(sx64(m) + sx64(x4_reg));
            ST_P7:  alth_reg  <= m;
            ST_P8:  alom_reg  <= m;
            ST_P9:  atc_reg   <= m;
            ST_P10: btc_reg   <= m;
            ST_P11: p_reg     <= m;
            ST_P12: z1_reg    <= m;
            ST_P13: cu_reg    <= m;
            ST_P14: z2_reg    <= m;
            ST_P15: y1_reg    <= m;
            ST_P16: pairs_reg <= sat32(sx64(z1_reg) + sx64(z2_reg) + sx64(m));
            ST_P17: y2_reg    <= m;
            ST_P18:
            begin
                alb_reg <= m;
                if (div_stat.done)
                    wnew_reg <= quo;
            end
            ST_P20: k0_reg <= sat32(sx64(y1_reg) - sx64(y2_reg) + sx64(m));
            ST_IT1: dv_reg <= m;
            ST_IT2: p_reg  <= m;
            ST_IT3: vv_reg <= m;
            ST_IT4: cu_reg <= m;
            ST_IT5: sv_reg <= m;
            ST_IT6:
            begin
                f_reg <= sat32(sx64(dv_reg) + sx64(m) + sx64(k0_reg));
                q_reg <= sat32(sx64(vv_reg) + sx64(vv_reg) + sx64(vv_reg)
                               - (sx64(sv_reg) <<< 1) + sx64(pairs_reg));
            end
            ST_IT7: ddf_reg <= m;
            ST_IT8: df_reg  <= sat32(sx64(d32) + sx64(m));
            ST_IT9:
            begin
                if (df_reg == 32'sd0)
                    flat_reg <= 1'b1;
            end
            ST_H1:  hn_reg <= sat32(sx64(m) <<< 1);
            ST_H2:  dd_reg <= m;
            ST_H3:  hd_reg <= sat32((sx64(dd_reg) <<< 1) - sx64(m));
            ST_ITD:
            begin
                if (div_stat.done)
                    v_reg <= vn;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    o_node_reg  <= node_reg;
                    o_v_reg     <= v_reg;
                    o_w_reg     <= wnew_reg;
                    o_steps_reg <= (steps9 > 9'd127) ? 7'd127 : steps9[6:0];
                    o_flat_reg  <= flat_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, o_steps_reg, o_w_reg, o_v_reg, o_node_reg};
    assign m_tuser  = o_flat_reg;

    // the divider is never restarted while a division is in flight
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // the store is never read and written in the same cycle
    a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store read and write collide");

    // the iteration count stays within its bound
    a_steps: assert property (@(posedge clk) disable iff (!rst_n)
        steps9 <= 9'(MAX_STEPS + 1))
        else $error("iteration count out of range");

    // a finished item is delivered as soon as the output register is free
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> m_tvalid)
        else $error("result not presented");

endmodule

// File: verif/fhn_reaction_newton_step_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhn_reaction_newton_step_checker
// Watches the input, result and configuration channels of the reaction
// solver. Predicts each result from its own copy of the registers and of the
// per-node recovery store, then compares every accepted result field by field.
// ---------------------------------------------------------------------------
module fhn_reaction_newton_step_checker
    import fhn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [47:0]          s_tdata,   // node_index[11:0], potential[43:12]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [87:0]          m_tdata,   // node_out[11:0], new_potential[43:12],
                                            // new_recovery[75:44], steps_taken[82:76]
    input  logic                 m_tuser,   // flat_stop[0]
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   fail_count,
    output int                   pending_count
);

    typedef logic signed [63:0] wide_t;

    typedef struct {
        logic [11:0]        node;
        logic signed [31:0] potential;
        logic signed [31:0] recovery;
        logic [6:0]         steps;
        logic               flat;
    } solve_res_t;

    localparam wide_t Q_ONE   = 64'sd65536;
    localparam wide_t POS_MAX = 64'sd2147483647;
    localparam wide_t NEG_MIN = -64'sd2147483648;

    // register copies, reset values
    wide_t inv_q     = 64'sd65536;
    wide_t alpha_q   = 64'sd32768;
    wide_t theta_q   = 64'sd32768;
    wide_t gain_q    = 64'sd65536;
    wide_t rest_q    = 64'sd0;
    wide_t thr_q     = 64'sd6554;
    wide_t dep_q     = 64'sd65536;
    logic  newton_on = 1'b1;

    logic signed [31:0] w_mem [NODE_COUNT_DEF];
    solve_res_t         solved_q [$];

    initial
    begin
        for (int i = 0; i < NODE_COUNT_DEF; i++)
            w_mem[i] = '0;
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic wide_t clamp(input wide_t x);
        if (x > POS_MAX)
            return POS_MAX;
        if (x < NEG_MIN)
            return NEG_MIN;
        return x;
    endfunction

    // product floored back to Q16.16
    function automatic wide_t fx_mul(input wide_t a, input wide_t b);
        wide_t p;
        p = clamp(a) * clamp(b);
        return clamp(p >>> 16);
    endfunction

    // quotient truncated toward zero, divide by zero saturates to numerator sign
    function automatic wide_t fx_div(input wide_t a, input wide_t b);
        wide_t n;
        wide_t d;
        n = clamp(a) * Q_ONE;
        d = clamp(b);
        if (d == 0)
            return (n > 0) ? POS_MAX : ((n < 0) ? NEG_MIN : 64'sd0);
        return clamp(n / d);
    endfunction

    function automatic wide_t cubic_term(input wide_t x);
        return fx_mul(fx_mul(clamp(x - rest_q), clamp(x - dep_q)), clamp(x - thr_q));
    endfunction

    function automatic solve_res_t solve_node(input logic [11:0] node,
                                              input logic signed [31:0] pot);
        solve_res_t r;
        wide_t v0, w, omt, ag, den, num, w_new, atc, btc, k0, s, pairs;
        wide_t v, vn, err, f, q, df, ddf, hn, hd;
        int    steps;
        logic  flat;
        v0    = pot;
        w     = w_mem[node];
        omt   = Q_ONE - theta_q;
        ag    = fx_mul(alpha_q, GAMMA_Q_DEF);
        den   = clamp(inv_q + fx_mul(ag, theta_q));
        num   = clamp(fx_mul(clamp(inv_q - fx_mul(ag, omt)), w)
                      + fx_mul(fx_mul(alpha_q, DELTA_Q_DEF), v0));
        w_new = fx_div(num, den);
        atc   = fx_mul(fx_mul(alpha_q, theta_q), gain_q);
        btc   = fx_mul(fx_mul(alpha_q, omt), gain_q);
        k0    = clamp(-fx_mul(inv_q, v0) + fx_mul(btc, cubic_term(v0))
                      + fx_mul(fx_mul(alpha_q, BETA_Q_DEF), w_new));
        s     = clamp(rest_q + dep_q + thr_q);
        pairs = clamp(fx_mul(thr_q, dep_q) + fx_mul(thr_q, rest_q) + fx_mul(rest_q, dep_q));
        v     = v0;
        err   = 1;
        steps = 0;
        flat  = 1'b0;
        // iterate until the update vanishes, the step budget runs out or F' is zero
        while (steps <= MAX_STEPS_DEF && err != 0)
        begin
            f  = clamp(fx_mul(inv_q, v) + fx_mul(atc, cubic_term(v)) + k0);
            q  = clamp(3 * fx_mul(v, v) - 2 * fx_mul(s, v) + pairs);
            df = clamp(inv_q + fx_mul(atc, q));
            if (df == 0)
            begin
                flat = 1'b1;
                break;
            end
            if (newton_on)
                vn = clamp(v - fx_div(f, df));
            else
            begin
                ddf = fx_mul(atc, clamp(6 * v - 2 * s));
                hn  = clamp(2 * fx_mul(f, df));
                hd  = clamp(2 * fx_mul(df, df) - fx_mul(f, ddf));
                vn  = clamp(v - fx_div(hn, hd));
            end
            err = vn - v;
            v   = vn;
            steps++;
        end
        w_mem[node] = w_new[31:0];
        r.node      = node;
        r.potential = v[31:0];
        r.recovery  = w_new[31:0];
        r.steps     = (steps > 127) ? 7'd127 : 7'(steps);
        r.flat      = flat;
        return r;
    endfunction

    // compare results, predict new items, track register writes
    always @(posedge clk)
    begin
        solve_res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (solved_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, got %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                exp_r = solved_q.pop_front();
                if (m_tdata[11:0] !== exp_r.node)
                begin
                    $display("%0t: node_out expected %0d got %0d", $time, exp_r.node,
                             m_tdata[11:0]);
                    fail_count++;
                end
                if (m_tdata[43:12] !== exp_r.potential)
                begin
                    $display("%0t: new_potential expected %h got %h", $time,
                             exp_r.potential, m_tdata[43:12]);
                    fail_count++;
                end
                if (m_tdata[75:44] !== exp_r.recovery)
                begin
                    $display("%0t: new_recovery expected %h got %h", $time,
                             exp_r.recovery, m_tdata[75:44]);
                    fail_count++;
                end
                if (m_tdata[82:76] !== exp_r.steps)
                begin
                    $display("%0t: steps_taken expected %0d got %0d", $time, exp_r.steps,
                             m_tdata[82:76]);
                    fail_count++;
                end
                if (m_tuser !== exp_r.flat)
                begin
                    $display("%0t: flat_stop expected %0b got %0b", $time, exp_r.flat,
                             m_tuser);
                    fail_count++;
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            solved_q.push_back(solve_node(s_tdata[11:0], s_tdata[43:12]));
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INV_STEP:  inv_q     = {33'd0, cfg_data[30:0]};
                CFG_SPLIT:     alpha_q   = {47'd0, cfg_data[16:0]};
                CFG_IMPLICIT:  theta_q   = {47'd0, cfg_data[16:0]};
                CFG_GAIN:      gain_q    = signed'(cfg_data);
                CFG_REST:      rest_q    = signed'(cfg_data);
                CFG_THRESHOLD: thr_q     = signed'(cfg_data);
                CFG_DEPOLAR:   dep_q     = signed'(cfg_data);
                CFG_MODE:      newton_on = cfg_data[0];
                default:       ;
            endcase
        end
        pending_count = solved_q.size();
    end

endmodule

// File: verif/fhn_reaction_newton_step_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fhn_reaction_newton_step_unit_tb
// Drives node potentials and register settings into the reaction solver with
// random idling on both sides; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module fhn_reaction_newton_step_unit_tb;
    import fhn_pkg::*;

    localparam int STALL_LIMIT = 60000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [87:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    int                   fail_count;
    int                   pending_count;
    logic                 calm = 1'b0;
    int                   sent_items = 0;
    int                   idle_cycles = 0;

    fhn_reaction_newton_step_unit dut (.*);
    fhn_reaction_newton_step_checker chk (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 19);

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("fhn_reaction_newton_step_unit: mismatch");
            $finish;
        end
    end

    task automatic send_potential(input logic [11:0] node, input logic signed [31:0] pot);
        while (!calm && $urandom_range(99) < 19)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'd0, pot, node};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        sent_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        s_tvalid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // hold until every result is back
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic send_random(input int count);
        logic [11:0]        node;
        logic signed [31:0] pot;
        for (int i = 0; i < count; i++)
        begin
            node = ($urandom_range(9) < 7) ? 12'($urandom_range(31)) : 12'($urandom);
            if ($urandom_range(7) == 0)
                pot = $urandom;
            else
                pot = $signed($urandom_range(524288)) - 32'sd262144;
            send_potential(node, pot);
        end
    endtask

    task automatic random_settings();
        write_reg(CFG_INV_STEP, $urandom_range(8 * 65536, 16384));
        write_reg(CFG_SPLIT, $urandom_range(65536));
        write_reg(CFG_IMPLICIT, ($urandom_range(3) == 0) ? $urandom_range(131071)
                                                         : $urandom_range(65536));
        write_reg(CFG_GAIN, $signed($urandom_range(262144)) - 32'sd131072);
        write_reg(CFG_REST, $signed($urandom_range(32768)) - 32'sd16384);
        write_reg(CFG_THRESHOLD, $urandom_range(32768));
        write_reg(CFG_DEPOLAR, $urandom_range(131072, 32768));
        write_reg(CFG_MODE, $urandom_range(1));
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes and repeated nodes at reset settings
        send_potential(12'd0, 32'sd0);
        send_potential(12'd4095, 32'sh7FFF_FFFF);
        send_potential(12'd4095, 32'sh8000_0000);
        send_potential(12'd0, 32'sd65536);
        send_potential(12'd0, 32'sd65536);
        send_potential(12'd1, -32'sd1);
        send_potential(12'd2, 32'sd1);
        send_potential(12'd2730, 32'sh5555_5555);
        send_potential(12'd1365, 32'shAAAA_AAAA);
        send_potential(12'd3, 32'sd6554);
        send_potential(12'd4, 32'sd131072);
        send_potential(12'd5, -32'sd65536);
        send_potential(12'd0, 32'sd98304);
        drain();

        // Halley update, plus a write to an unused index that must be ignored
        write_reg(CFG_MODE, 32'd0);
        write_reg(4'd12, 32'hFFFF_FFFF);
        send_potential(12'd0, 32'sd65536);
        send_potential(12'd4095, 32'sh7FFF_FFFF);
        send_potential(12'd7, 32'sh8000_0000);
        send_random(80);
        drain();

        // zero derivative and zero recovery divisor
        write_reg(CFG_INV_STEP, 32'd0);
        write_reg(CFG_SPLIT, 32'd0);
        write_reg(CFG_MODE, 32'd1);
        send_random(20);
        drain();

        // extremes, theta above one
        write_reg(CFG_INV_STEP, 32'h7FFF_FFFF);
        write_reg(CFG_SPLIT, 32'd65536);
        write_reg(CFG_IMPLICIT, 32'd131071);
        write_reg(CFG_GAIN, 32'h8000_0000);
        write_reg(CFG_REST, 32'h7FFF_FFFF);
        write_reg(CFG_THRESHOLD, 32'h8000_0000);
        write_reg(CFG_DEPOLAR, 32'h7FFF_FFFF);
        send_random(40);
        drain();

        // random settings, one phase with no idling
        for (int ph = 0; ph < 4; ph++)
        begin
            random_settings();
            calm = (ph == 1);
            send_random(95);
            drain();
        end
        calm = 1'b0;

        $display("Sent %0d node updates over eight register settings,", sent_items);
        $display("covering Newton and Halley modes, zero derivative and saturation.");
        if (fail_count == 0)
            $display("fhn_reaction_newton_step_unit: match");
        else
            $display("fhn_reaction_newton_step_unit: mismatch");
        $finish;
    end

endmodule
